/* rtl/core/modelview_matrix_stack_unit_core_defines.svh */
// Assertion macros for the checker file of the matrix stack unit.
`ifndef MODELVIEW_MATRIX_STACK_UNIT_CORE_DEFINES_SVH
`define MODELVIEW_MATRIX_STACK_UNIT_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define MVSU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MVSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mvsu_pkg.sv */
`default_nettype none
package mvsu_pkg;

  typedef enum logic [3:0] {
    OP_IDENTITY  = 4'd0,
    OP_WRITE     = 4'd1,
    OP_READ      = 4'd2,
    OP_PUSH      = 4'd3,
    OP_POP       = 4'd4,
    OP_TRANSLATE = 4'd5,
    OP_SCALE     = 4'd6,
    OP_ROTX      = 4'd7,
    OP_ROTY      = 4'd8,
    OP_ROTZ      = 4'd9,
    OP_TRANSFORM = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Whole matrix as one word, element [row][column].
  typedef logic [3:0][3:0][31:0] mat_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic signed [17:0] sine;
    logic signed [17:0] cosine;
    logic [1:0]         row;
    logic [1:0]         column;
    logic signed [31:0] element;
  } cmd_t;

  typedef struct packed {
    logic stack_full;
    logic stack_empty;
  } stack_flags_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic signed [31:0] element_out;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/mvsu_ram.sv */
`default_nettype none
module mvsu_ram #(
  parameter int WIDTH = 512,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mvsu_alu.sv */
`default_nettype none
module mvsu_alu import mvsu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire  mat_t         matrix,
  input  wire  mat_t         popped,
  input  wire  cmd_t         cmd,
  input  wire  stack_flags_t flags,
  output mat_t               matrix_next,
  output result_t            result
);

  localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

  // Product shifted right by the fraction width, floor rounding.
  function automatic logic signed [65:0] qm(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return 66'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] sat(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -66'sh80000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] sn32, cs32;
  logic [1:0]         ra, rb;
  logic               flip;
  logic [3:0][31:0]   rot_a, rot_b, trans;

  assign sn32 = 32'(cmd.sine);
  assign cs32 = 32'(cmd.cosine);

  always_comb begin
    ra   = 2'd0;
    rb   = 2'd1;
    flip = 1'b0;
    case (cmd.operation)
      OP_ROTX: begin ra = 2'd1; rb = 2'd2; end
      OP_ROTY: begin ra = 2'd0; rb = 2'd2; flip = 1'b1; end
      default: begin ra = 2'd0; rb = 2'd1; end
    endcase
  end

  // Per column: rotation of two rows and the row-weighted sum of translate/transform.
  always_comb begin
    logic signed [31:0] sa, sb;
    logic signed [65:0] ta, tb, pa, pb;
    for (int c = 0; c < 4; c++) begin
      sa = $signed(matrix[ra][c]);
      sb = $signed(matrix[rb][c]);
      ta = qm(sa, cs32);
      tb = qm(sb, cs32);
      pa = qm(sa, sn32);
      pb = qm(sb, sn32);
      rot_a[c] = flip ? sat(ta - pb) : sat(ta + pb);
      rot_b[c] = flip ? sat(pa + tb) : sat(tb - pa);
      trans[c] = sat(qm($signed(matrix[0][c]), cmd.x_value)
                   + qm($signed(matrix[1][c]), cmd.y_value)
                   + qm($signed(matrix[2][c]), cmd.z_value)
                   + 66'($signed(matrix[3][c])));
    end
  end

  always_comb begin
    matrix_next        = matrix;
    result.status      = ST_OK;
    result.result_x    = '0;
    result.result_y    = '0;
    result.result_z    = '0;
    result.element_out = '0;
    case (cmd.operation)
      OP_IDENTITY: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            matrix_next[r][c] = (r == c) ? ONE : '0;
          end
        end
      end
      OP_WRITE: matrix_next[cmd.row][cmd.column] = cmd.element;
      OP_READ:  result.element_out = $signed(matrix[cmd.row][cmd.column]);
      OP_PUSH: begin
        if (flags.stack_full) result.status = ST_FULL;
      end
      OP_POP: begin
        if (flags.stack_empty) result.status = ST_EMPTY;
        else matrix_next = popped;
      end
      OP_TRANSLATE: matrix_next[3] = trans;
      OP_SCALE: begin
        for (int c = 0; c < 4; c++) begin
          matrix_next[0][c] = sat(qm(cmd.x_value, $signed(matrix[0][c])));
          matrix_next[1][c] = sat(qm(cmd.y_value, $signed(matrix[1][c])));
          matrix_next[2][c] = sat(qm(cmd.z_value, $signed(matrix[2][c])));
        end
      end
      OP_ROTX, OP_ROTY, OP_ROTZ: begin
        matrix_next[ra] = rot_a;
        matrix_next[rb] = rot_b;
      end
      OP_TRANSFORM: begin
        result.result_x = $signed(trans[0]);
        result.result_y = $signed(trans[1]);
        result.result_z = $signed(trans[2]);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/modelview_matrix_stack_unit_core.sv */
// Modelview matrix stack unit.
// Commands arrive on the input channel (in_valid / in_stall) one beat at a time;
// each command yields exactly one result beat on the output channel
// (out_valid / out_stall), in command order.
// A beat is taken into a command register, executed by single-pass logic and
// written to the result register once the output side is free; the result beat
// is offered from that register. One command is taken
// per cycle while the receiver does not stall; a pop that finds a non-empty stack first waits,
// because the saved matrix is read from the stack memory, whose read port is registered.
// The output register and the command register decouple the two sides: a
// new beat is accepted while an earlier result waits. While the receiver
// stalls, the result holds and the command register fills, then in_stall rises.
// Reset (synchronous, active high) loads the identity matrix, empties the
// stack and drops both valid flags. Stack memory contents are not cleared;
// only entries written by a push are ever read back.
`default_nettype none
module modelview_matrix_stack_unit_core import mvsu_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         operation,
  input  wire logic signed [31:0] x_value,
  input  wire logic signed [31:0] y_value,
  input  wire logic signed [31:0] z_value,
  input  wire logic signed [17:0] sine,
  input  wire logic signed [17:0] cosine,
  input  wire logic [1:0]         row,
  input  wire logic [1:0]         column,
  input  wire logic signed [31:0] element,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic signed [31:0]      result_x,
  output logic signed [31:0]      result_y,
  output logic signed [31:0]      result_z,
  output logic signed [31:0]      element_out,
  output logic [5:0]              stack_count
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
  localparam logic [31:0]   ONE = 32'(64'(1) << FRAC_BITS);

  // Command register.
  cmd_t          cmd;
  logic          cmd_valid;
  logic          pop_phase;

  mat_t          matrix, matrix_next, popped;
  logic [LW-1:0] level, level_next;
  stack_flags_t  flags;
  result_t       res;

  logic accept, exec_go, pop_wait, out_free, is_push, is_pop;

  assign flags.stack_full  = (level >= DEPTH_L);
  assign flags.stack_empty = (level == '0);
  assign is_push = (cmd.operation == OP_PUSH);
  assign is_pop  = (cmd.operation == OP_POP);

  // A pop from a non-empty stack first waits for the memory read.
  assign pop_wait = cmd_valid && is_pop && !flags.stack_empty && !pop_phase;
  assign out_free = !out_valid || !out_stall;
  assign exec_go  = cmd_valid && !pop_wait && out_free;
  assign in_stall = cmd_valid && !exec_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= '{operation: operation, x_value: x_value, y_value: y_value,
               z_value: z_value, sine: sine, cosine: cosine, row: row,
               column: column, element: element};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      pop_phase <= 1'b0;
    end else begin
      if (accept) cmd_valid <= 1'b1;
      else if (exec_go) cmd_valid <= 1'b0;
      if (exec_go) pop_phase <= 1'b0;
      else if (pop_wait) pop_phase <= 1'b1;
    end
  end

  mvsu_ram #(
    .WIDTH($bits(mat_t)),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (exec_go && is_push && !flags.stack_full),
    .wr_addr(level[AW-1:0]),
    .wr_data(matrix),
    .rd_en  (pop_wait),
    .rd_addr(AW'(level - LW'(1))),
    .rd_data(popped)
  );

  mvsu_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .matrix     (matrix),
    .popped     (popped),
    .cmd        (cmd),
    .flags      (flags),
    .matrix_next(matrix_next),
    .result     (res)
  );

  always_comb begin
    level_next = level;
    case (cmd.operation)
      OP_IDENTITY: level_next = '0;
      OP_PUSH: if (!flags.stack_full) level_next = level + LW'(1);
      OP_POP:  if (!flags.stack_empty) level_next = level - LW'(1);
      default: ;
    endcase
  end

  // Matrix and stack level.
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          matrix[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (exec_go) begin
      level  <= level_next;
      matrix <= matrix_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status      <= res.status;
      result_x    <= res.result_x;
      result_y    <= res.result_y;
      result_z    <= res.result_z;
      element_out <= res.element_out;
      stack_count <= 6'(level_next);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mvsu_checker.sv */
`default_nettype none
`include "modelview_matrix_stack_unit_core_defines.svh"
module mvsu_checker import mvsu_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [5:0]  stack_count
);

  `MVSU_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result beat dropped")
  `MVSU_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result after reset")
  `MVSU_ASSERT(a_status_code, clk, rst, out_valid |-> status != 2'd3, "bad status code")
  `MVSU_ASSERT(a_count_range, clk, rst, out_valid |-> 7'(stack_count) <= 7'(STACK_DEPTH), "stack count overflow")

endmodule

bind modelview_matrix_stack_unit_core mvsu_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_mvsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .stack_count(stack_count)
);
`default_nettype wire

/* dv/modelview_matrix_stack_unit_core_checker.sv */
`default_nettype none
module modelview_matrix_stack_unit_core_checker import mvsu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [3:0]         operation,
  input  wire logic signed [31:0] x_value,
  input  wire logic signed [31:0] y_value,
  input  wire logic signed [31:0] z_value,
  input  wire logic signed [17:0] sine,
  input  wire logic signed [17:0] cosine,
  input  wire logic [1:0]         row,
  input  wire logic [1:0]         column,
  input  wire logic signed [31:0] element,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         status,
  input  wire logic signed [31:0] result_x,
  input  wire logic signed [31:0] result_y,
  input  wire logic signed [31:0] result_z,
  input  wire logic signed [31:0] element_out,
  input  wire logic [5:0]         stack_count,
  output int                      fail_count,
  output int                      pending,
  output int                      result_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int FRAC  = 16;

  typedef struct {
    logic [1:0]         st;
    logic signed [31:0] rx, ry, rz, eo;
    logic [5:0]         cnt;
  } beat_t;

  logic signed [31:0] mtx [4][4];
  logic signed [31:0] saved [DEPTH][4][4];
  int                 level;
  beat_t              expected_q [$];

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rows a and b: a = a*cs + s*b*sn, b = b*cs - s*a*sn, with s = -1 when flipped.
  task automatic rotate(int a, int b, longint sn, longint cs, bit flip);
    longint sa, sb;
    for (int c = 0; c < 4; c++) begin
      sa = longint'(mtx[a][c]);
      sb = longint'(mtx[b][c]);
      if (flip) begin
        mtx[a][c] = clip(fmul(sa, cs) - fmul(sb, sn));
        mtx[b][c] = clip(fmul(sa, sn) + fmul(sb, cs));
      end else begin
        mtx[a][c] = clip(fmul(sa, cs) + fmul(sb, sn));
        mtx[b][c] = clip(fmul(sb, cs) - fmul(sa, sn));
      end
    end
  endtask

  task automatic load_identity();
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        mtx[r][c] = (r == c) ? 32'sd65536 : 32'sd0;
  endtask

  task automatic execute_command();
    beat_t              b;
    longint             x, y, z, sn, cs;
    logic signed [31:0] pt [3];
    x = longint'(x_value); y = longint'(y_value); z = longint'(z_value);
    sn = longint'(sine); cs = longint'(cosine);
    b.st = ST_OK; b.rx = 0; b.ry = 0; b.rz = 0; b.eo = 0;
    case (operation)
      OP_IDENTITY: begin
        level = 0;
        load_identity();
      end
      OP_WRITE: mtx[row][column] = element;
      OP_READ:  b.eo = mtx[row][column];
      OP_PUSH: begin
        if (level >= DEPTH) b.st = ST_FULL;
        else begin
          saved[level] = mtx;
          level++;
        end
      end
      OP_POP: begin
        if (level == 0) b.st = ST_EMPTY;
        else begin
          level--;
          mtx = saved[level];
        end
      end
      OP_TRANSLATE:
        for (int c = 0; c < 4; c++)
          mtx[3][c] = clip(fmul(longint'(mtx[0][c]), x) + fmul(longint'(mtx[1][c]), y)
                           + fmul(longint'(mtx[2][c]), z) + longint'(mtx[3][c]));
      OP_SCALE:
        for (int c = 0; c < 4; c++) begin
          mtx[0][c] = clip(fmul(x, longint'(mtx[0][c])));
          mtx[1][c] = clip(fmul(y, longint'(mtx[1][c])));
          mtx[2][c] = clip(fmul(z, longint'(mtx[2][c])));
        end
      OP_ROTX: rotate(1, 2, sn, cs, 1'b0);
      OP_ROTY: rotate(0, 2, sn, cs, 1'b1);
      OP_ROTZ: rotate(0, 1, sn, cs, 1'b0);
      OP_TRANSFORM: begin
        for (int c = 0; c < 3; c++)
          pt[c] = clip(fmul(longint'(mtx[0][c]), x) + fmul(longint'(mtx[1][c]), y)
                       + fmul(longint'(mtx[2][c]), z) + longint'(mtx[3][c]));
        b.rx = pt[0]; b.ry = pt[1]; b.rz = pt[2];
      end
      default: ;
    endcase
    b.cnt = level[5:0];
    expected_q.push_back(b);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_total = 0;
    pending = 0;
    level = 0;
    load_identity();
  end

  always @(posedge clk) begin
    beat_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        result_total++;
        if (expected_q.size() == 0) begin
          $display("%0t result beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (status !== e.st) report("status", 32'(status), 32'(e.st));
          if (result_x !== e.rx) report("result_x", result_x, e.rx);
          if (result_y !== e.ry) report("result_y", result_y, e.ry);
          if (result_z !== e.rz) report("result_z", result_z, e.rz);
          if (element_out !== e.eo) report("element_out", element_out, e.eo);
          if (stack_count !== e.cnt) report("stack_count", 32'(stack_count), 32'(e.cnt));
        end
      end
      if (in_valid && !in_stall) execute_command();
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

/* dv/modelview_matrix_stack_unit_core_tb.sv */
`default_nettype none
module modelview_matrix_stack_unit_core_tb import mvsu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         operation;
  logic signed [31:0] x_value, y_value, z_value, element;
  logic signed [17:0] sine, cosine;
  logic [1:0]         row, column;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic signed [31:0] result_x, result_y, result_z, element_out;
  logic [5:0]         stack_count;
  int                 fail_count, pending, result_total;
  int                 sent;
  int                 push_depth;
  bit                 calm;

  modelview_matrix_stack_unit_core u_dut (.*);
  modelview_matrix_stack_unit_core_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random with a 12 percent chance, except in the calm stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  initial begin
    #50ms;
    $display("timeout after %0d commands, %0d results pending", sent, pending);
    $display("modelview_matrix_stack_unit_core_tb NOT OK");
    $finish;
  end

  // A Q16.16 value drawn from a mix of extremes, small numbers and full noise.
  function automatic logic signed [31:0] qval();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(131072)) - 32'sd65536;
    endcase
  endfunction

  function automatic logic signed [17:0] trig();
    case ($urandom_range(9))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      default: return 18'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // Send one command beat. The sender may idle first; valid stays high from
  // one beat to the next with no gap, and the payload holds while stalled.
  task automatic send(logic [3:0] op, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic signed [17:0] sn,
                      logic signed [17:0] cs, logic [1:0] r, logic [1:0] c,
                      logic signed [31:0] el);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    x_value <= x; y_value <= y; z_value <= z;
    sine <= sn; cosine <= cs; row <= r; column <= c; element <= el;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_op(logic [3:0] op);
    send(op, qval(), qval(), qval(), trig(), trig(), 2'($urandom), 2'($urandom), qval());
  endtask

  task automatic random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)        send_op(4'(11 + $urandom_range(4)));
    else if (pick < 10)  send_op(OP_IDENTITY);
    else if (pick < 20)  send_op(OP_WRITE);
    else if (pick < 30)  send_op(OP_READ);
    else if (pick < 42)  send_op(OP_PUSH);
    else if (pick < 54)  send_op(OP_POP);
    else if (pick < 62)  send_op(OP_TRANSLATE);
    else if (pick < 68)  send_op(OP_SCALE);
    else if (pick < 74)  send_op(OP_ROTX);
    else if (pick < 80)  send_op(OP_ROTY);
    else if (pick < 86)  send_op(OP_ROTZ);
    else                 send_op(OP_TRANSFORM);
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b1;
    sent = 0;
    in_valid = 1'b0;
    operation = '0;
    x_value = '0; y_value = '0; z_value = '0; element = '0;
    sine = '0; cosine = '0; row = '0; column = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: pop on an empty stack, every operation with extreme
    // operands, a subtracted term in rotate y, and unused codes.
    send(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRANSFORM, 32'sh7fffffff, 32'sh80000000, 32'sd65536, 0, 0, 0, 0, 0);
    send(OP_WRITE, 0, 0, 0, 0, 0, 2'd3, 2'd3, 32'sh80000000);
    send(OP_WRITE, 0, 0, 0, 0, 0, 2'd0, 2'd1, 32'sh7fffffff);
    send(OP_READ, 0, 0, 0, 0, 0, 2'd3, 2'd3, 0);
    send(OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRANSLATE, 32'sh7fffffff, 32'sh80000000, -32'sd1, 0, 0, 0, 0, 0);
    send(OP_SCALE, 32'sh80000000, 32'sh7fffffff, -32'sd65536, 0, 0, 0, 0, 0);
    send(OP_ROTX, 0, 0, 0, 18'sd65536, -18'sd65536, 0, 0, 0);
    send(OP_ROTY, 0, 0, 0, 18'sh1ffff, 18'sh20000, 0, 0, 0);
    send(OP_ROTZ, 0, 0, 0, -18'sd65536, 18'sd65536, 0, 0, 0);
    send(OP_TRANSFORM, -32'sd1, 32'sd3, 32'sh80000000, 0, 0, 0, 0, 0);
    send(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0);
    send(4'd11, 32'shffffffff, 32'shffffffff, 32'shffffffff, 18'h3ffff, 18'h3ffff,
         2'd3, 2'd3, 32'shffffffff);
    send(4'd15, 0, 0, 0, 0, 0, 0, 0, 0);
    // Fill the stack and push once more onto the full stack.
    for (int k = 0; k < 33; k++) send(OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_IDENTITY, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0);

    // Calm stretch ends here; random idling from now on.
    calm = 1'b0;
    for (int k = 0; k < 450; k++) begin
      // The sender holds off until every expected result is back.
      if (k == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      // Now and then drive the stack deep, at times to full, and back down with real content.
      if (k % 250 == 100) begin
        push_depth = $urandom_range(28, 34);
        for (int j = 0; j < push_depth; j++) begin
          send_op(OP_PUSH);
          send_op(OP_ROTZ);
        end
        for (int j = 0; j < push_depth; j++) begin
          send_op(OP_POP);
          send_op(OP_READ);
        end
      end
      random_command();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d commands over all operations, full and empty stack cases,", sent);
    $display("and saturating arithmetic; %0d result beats were checked.", result_total);
    if (fail_count == 0) begin
      $display("modelview_matrix_stack_unit_core_tb OK");
    end else begin
      $display("modelview_matrix_stack_unit_core_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
